FILE: sv/hadamard_gate_state_vector_assert.svh
// ----------------------------------------------------------------------------
// Hadamard gate state vector: assertion macros
// Concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef HADAMARD_GATE_STATE_VECTOR_ASSERT_SVH
`define HADAMARD_GATE_STATE_VECTOR_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked while reset is released.
`define HGSV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Property checked at every edge, reset included.
`define HGSV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define HGSV_ASSERT(lbl, clk, rst_n, prop)
`define HGSV_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: sv/hgsv_pkg.sv
// ----------------------------------------------------------------------------
// Hadamard gate state vector: package
// Shared codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hgsv_pkg;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_QUBIT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_QUBIT = 1'd1;

    localparam logic [CFG_W-1:0] QUBIT_COUNT_RST  = 4'd10;
    localparam logic [CFG_W-1:0] TARGET_QUBIT_RST = 4'd1;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_GATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_GATE = 1'b1;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_BAD_TARGET = 1'b1;

    // 1/sqrt(2) in Q0.16, kept as a positive signed 18-bit value.
    localparam logic signed [17:0] INV_SQRT2_Q16 = 18'sd46341;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OUT,
        ST_G_RDA,
        ST_G_RDB,
        ST_G_SUM,
        ST_G_MUL,
        ST_G_WRA,
        ST_G_WRB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_input;      // store the input amplitude at the input index
        logic rd_input;      // read the entry at the input index
        logic start_gate;    // latch mask and clear the pair counter
        logic rd_i;          // read the lower entry of the current pair
        logic rd_j;          // read the upper entry of the current pair
        logic cap_a;         // hold the lower entry
        logic calc_sum;      // register a+b and a-b
        logic calc_mul;      // register the scaled products
        logic wr_i;          // write the rounded sum to the lower entry
        logic wr_j;          // write the rounded difference to the upper entry
        logic step;          // advance to the next pair
        logic out_load_read; // load read data into the output register
        logic out_load_gate; // load a gate result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic gate_ok;       // target qubit lies in 1..n
        logic last_pair;     // current pair is the final one
        logic out_free;      // output register can take a result this cycle
    } t_dp_stat;

endpackage

FILE: sv/hgsv_ctrl.sv
// ----------------------------------------------------------------------------
// Hadamard gate state vector: controller
// Sequences reads, writes and the pair walk of the gate.
// ----------------------------------------------------------------------------
module hgsv_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [hgsv_pkg::OP_W-1:0]    i_op,
    output logic                         o_ready,
    input  hgsv_pkg::t_dp_stat           i_stat,
    output hgsv_pkg::t_dp_cmd            o_cmd
);
    import hgsv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_op)
                        OP_WRITE: begin
                            o_cmd.wr_input = 1'b1;
                        end
                        OP_READ: begin
                            o_cmd.rd_input = 1'b1;
                            n_state = ST_RD_OUT;
                        end
                        OP_GATE: begin
                            o_cmd.start_gate = 1'b1;
                            n_state = i_stat.gate_ok ? ST_G_RDA : ST_DONE;
                        end
                        default: begin
                            // Unused op code: the item is taken and dropped.
                        end
                    endcase
                end
            end
            ST_RD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load_read = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_G_RDA: begin
                o_cmd.rd_i = 1'b1;
                n_state = ST_G_RDB;
            end
            ST_G_RDB: begin
                o_cmd.rd_j  = 1'b1;
                o_cmd.cap_a = 1'b1;
                n_state = ST_G_SUM;
            end
            ST_G_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state = ST_G_MUL;
            end
            ST_G_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state = ST_G_WRA;
            end
            ST_G_WRA: begin
                o_cmd.wr_i = 1'b1;
                n_state = ST_G_WRB;
            end
            ST_G_WRB: begin
                o_cmd.wr_j = 1'b1;
                o_cmd.step = 1'b1;
                n_state = i_stat.last_pair ? ST_DONE : ST_G_RDA;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load_gate = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/hgsv_dp.sv
// ----------------------------------------------------------------------------
// Hadamard gate state vector: datapath
// Amplitude memory, configuration, pair counter, butterfly and output register.
// ----------------------------------------------------------------------------
module hgsv_dp #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hgsv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hgsv_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [MAX_QUBITS-1:0]               i_index,
    input  logic signed [AMP_WIDTH-1:0]         i_in_real,
    input  logic signed [AMP_WIDTH-1:0]         i_in_imag,
    input  hgsv_pkg::t_dp_cmd                   i_cmd,
    output hgsv_pkg::t_dp_stat                  o_stat,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic signed [AMP_WIDTH-1:0]         o_out_real,
    output logic signed [AMP_WIDTH-1:0]         o_out_imag,
    output logic                                o_kind,
    output logic                                o_status
);
    import hgsv_pkg::*;

    localparam int AW    = MAX_QUBITS;
    localparam int CW    = AW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = 2 * AMP_WIDTH;
    localparam int SW    = AMP_WIDTH + 1;
    localparam int PW    = SW + 18;
    localparam int RW    = PW - 16;
    localparam int QW    = ($clog2(MAX_QUBITS + 1) > CFG_W) ? $clog2(MAX_QUBITS + 1) : CFG_W;

    localparam logic signed [PW-1:0] RND_BIAS = PW'(32768);
    localparam logic signed [RW-1:0] SAT_HI =
        {{(RW - AMP_WIDTH + 1){1'b0}}, {(AMP_WIDTH - 1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO =
        {{(RW - AMP_WIDTH + 1){1'b1}}, {(AMP_WIDTH - 1){1'b0}}};

    // Round to nearest (ties up) after the Q0.16 scale, then saturate.
    function automatic logic signed [AMP_WIDTH-1:0] f_round_sat(
        input logic signed [PW-1:0] p
    );
        logic signed [PW-1:0] biased;
        logic signed [RW-1:0] r;
        biased = p + RND_BIAS;
        r = biased[PW-1:16];
        if (r > SAT_HI) begin
            return SAT_HI[AMP_WIDTH-1:0];
        end else if (r < SAT_LO) begin
            return SAT_LO[AMP_WIDTH-1:0];
        end
        return r[AMP_WIDTH-1:0];
    endfunction

    logic [CFG_W-1:0]   r_qubit_count;
    logic [CFG_W-1:0]   r_target_qubit;
    logic [DW-1:0]      r_mem [DEPTH];
    logic [DW-1:0]      r_rd_data;
    logic [DW-1:0]      r_a;
    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_mask;
    logic [CW-1:0]      r_len_mask;
    logic signed [SW-1:0] r_sum_re;
    logic signed [SW-1:0] r_sum_im;
    logic signed [SW-1:0] r_dif_re;
    logic signed [SW-1:0] r_dif_im;
    logic signed [PW-1:0] r_p_sum_re;
    logic signed [PW-1:0] r_p_sum_im;
    logic signed [PW-1:0] r_p_dif_re;
    logic signed [PW-1:0] r_p_dif_im;
    logic               r_out_valid;
    logic signed [AMP_WIDTH-1:0] r_out_real;
    logic signed [AMP_WIDTH-1:0] r_out_imag;
    logic               r_out_kind;
    logic               r_out_status;

    logic [QW-1:0]      n_eff;
    logic [QW-1:0]      k_cfg;
    logic [QW-1:0]      shift;
    logic               gate_ok;
    logic [AW-1:0]      mask_cfg;
    logic [CW-1:0]      len_mask_cfg;
    logic [CW-1:0]      next_i;
    logic [AW-1:0]      j_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [DW-1:0]      wr_data;
    logic               wr_en;
    logic               rd_en;
    logic signed [AMP_WIDTH-1:0] a_re;
    logic signed [AMP_WIDTH-1:0] a_im;
    logic signed [AMP_WIDTH-1:0] b_re;
    logic signed [AMP_WIDTH-1:0] b_im;
    logic signed [AMP_WIDTH-1:0] res_re;
    logic signed [AMP_WIDTH-1:0] res_im;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubit_count  <= QUBIT_COUNT_RST;
            r_target_qubit <= TARGET_QUBIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_QUBIT_COUNT:  r_qubit_count  <= i_cfg_data;
                REG_TARGET_QUBIT: r_target_qubit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Gate geometry from the configuration; n above the store size saturates.
    always_comb begin
        n_eff = (QW'(r_qubit_count) > QW'(MAX_QUBITS)) ? QW'(MAX_QUBITS)
                                                        : QW'(r_qubit_count);
        k_cfg        = QW'(r_target_qubit);
        gate_ok      = (k_cfg != '0) && (k_cfg <= n_eff);
        shift        = n_eff - k_cfg;
        mask_cfg     = AW'(1) << shift;
        len_mask_cfg = (CW'(1) << n_eff) - CW'(1);
    end

    // Next lower index with the mask bit clear: set the bit so the carry skips it.
    assign next_i = (({1'b0, r_i} | {1'b0, r_mask}) + CW'(1)) & ~{1'b0, r_mask};
    assign j_addr = r_i ^ r_mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_gate) begin
            r_i        <= '0;
            r_mask     <= mask_cfg;
            r_len_mask <= len_mask_cfg;
        end else if (i_cmd.step) begin
            r_i <= next_i[AW-1:0];
        end
    end

    // Memory ports.
    always_comb begin
        rd_en   = i_cmd.rd_input | i_cmd.rd_i | i_cmd.rd_j;
        rd_addr = i_cmd.rd_input ? i_index : (i_cmd.rd_j ? j_addr : r_i);
        res_re  = f_round_sat(i_cmd.wr_j ? r_p_dif_re : r_p_sum_re);
        res_im  = f_round_sat(i_cmd.wr_j ? r_p_dif_im : r_p_sum_im);
        wr_en   = i_cmd.wr_input | i_cmd.wr_i | i_cmd.wr_j;
        if (i_cmd.wr_input) begin
            wr_addr = i_index;
            wr_data = {i_in_real, i_in_imag};
        end else begin
            wr_addr = i_cmd.wr_j ? j_addr : r_i;
            wr_data = {res_re, res_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Butterfly: sums and differences, then the scale by 1/sqrt(2).
    assign a_re = r_a[DW-1:AMP_WIDTH];
    assign a_im = r_a[AMP_WIDTH-1:0];
    assign b_re = r_rd_data[DW-1:AMP_WIDTH];
    assign b_im = r_rd_data[AMP_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= r_rd_data;
        end
        if (i_cmd.calc_sum) begin
            r_sum_re <= SW'(a_re) + SW'(b_re);
            r_sum_im <= SW'(a_im) + SW'(b_im);
            r_dif_re <= SW'(a_re) - SW'(b_re);
            r_dif_im <= SW'(a_im) - SW'(b_im);
        end
        if (i_cmd.calc_mul) begin
            r_p_sum_re <= r_sum_re * INV_SQRT2_Q16;
            r_p_sum_im <= r_sum_im * INV_SQRT2_Q16;
            r_p_dif_re <= r_dif_re * INV_SQRT2_Q16;
            r_p_dif_im <= r_dif_im * INV_SQRT2_Q16;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_read || i_cmd.out_load_gate) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_read) begin
            r_out_real   <= r_rd_data[DW-1:AMP_WIDTH];
            r_out_imag   <= r_rd_data[AMP_WIDTH-1:0];
            r_out_kind   <= KIND_READ;
            r_out_status <= STATUS_OK;
        end else if (i_cmd.out_load_gate) begin
            r_out_real   <= '0;
            r_out_imag   <= '0;
            r_out_kind   <= KIND_GATE;
            r_out_status <= gate_ok ? STATUS_OK : STATUS_BAD_TARGET;
        end
    end

    assign o_stat.gate_ok   = gate_ok;
    assign o_stat.last_pair = (next_i & ~r_len_mask) != '0;
    assign o_stat.out_free  = !r_out_valid || i_ready;

    assign o_valid    = r_out_valid;
    assign o_out_real = r_out_real;
    assign o_out_imag = r_out_imag;
    assign o_kind     = r_out_kind;
    assign o_status   = r_out_status;

endmodule

FILE: sv/hadamard_gate_state_vector.sv
// ----------------------------------------------------------------------------
// Hadamard gate state vector
// Fixed-point complex state vector with write, read and Hadamard gate items.
// ----------------------------------------------------------------------------
// Items enter on i_valid/o_ready with i_op, i_index, i_in_real and i_in_imag.
// Results leave on o_valid/i_ready with o_out_real, o_out_imag, o_kind and
// o_status. Qubit count and target qubit are written through i_cfg_we,
// i_cfg_index and i_cfg_data, which the user must do only while the block is
// idle; the block does not enforce it. A write gives no result; writes can
// follow every cycle while the block is idle. A read loads the registered
// entry into the output register once that is free. A gate walks 2^(n-1)
// amplitude pairs through the memory in six steps a pair (two reads, add,
// multiply, two writes), then loads its result once the output register is
// free. A target outside 1..n reports status 1, leaving the vector untouched.
// One output register holds a finished result; a new item is taken while it
// waits, and a stalled receiver holds the next result back in the controller.
// Reset clears control state and restores qubit count 10 and target 1; the
// amplitude memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
`include "hadamard_gate_state_vector_assert.svh"

module hadamard_gate_state_vector #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hgsv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hgsv_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hgsv_pkg::OP_W-1:0]           i_op,
    input  logic [MAX_QUBITS-1:0]               i_index,
    input  logic signed [AMP_WIDTH-1:0]         i_in_real,
    input  logic signed [AMP_WIDTH-1:0]         i_in_imag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [AMP_WIDTH-1:0]         o_out_real,
    output logic signed [AMP_WIDTH-1:0]         o_out_imag,
    output logic                                o_kind,
    output logic                                o_status
);
    import hgsv_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hgsv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    hgsv_dp #(
        .MAX_QUBITS (MAX_QUBITS),
        .AMP_WIDTH  (AMP_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_index     (i_index),
        .i_in_real   (i_in_real),
        .i_in_imag   (i_in_imag),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_out_real  (o_out_real),
        .o_out_imag  (o_out_imag),
        .o_kind      (o_kind),
        .o_status    (o_status)
    );

    // The two halves of a butterfly are written in consecutive cycles.
    `HGSV_ASSERT(a_pair_writes, i_clk, i_rst_n, cmd.wr_i |=> cmd.wr_j)
    // A result is never loaded over one the receiver has not yet taken.
    `HGSV_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        (cmd.out_load_read || cmd.out_load_gate) |-> stat.out_free)
    // The block takes no new item while a gate is walking the memory.
    `HGSV_ASSERT(a_busy_not_ready, i_clk, i_rst_n,
        (cmd.rd_i || cmd.rd_j || cmd.wr_i || cmd.wr_j) |-> !o_ready)
    // The upper entry is read right after the lower one, then summed.
    `HGSV_ASSERT(a_read_order, i_clk, i_rst_n, cmd.rd_i |=> cmd.rd_j ##1 cmd.calc_sum)

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Hadamard gate state vector: testbench
// Drives write, read and gate items through the valid/ready channels and
// predicts every read and gate result from a copy of the amplitude memory.
// Results are checked field by field in order, under random idling on both
// sides, a long receiver hold-off and several qubit count and target settings.
// ----------------------------------------------------------------------------
module tb_top;
    import hgsv_pkg::*;

    localparam int NQ_MAX    = 10;
    localparam int AMP_W     = 16;
    localparam int DEPTH     = 1 << NQ_MAX;
    localparam int AMP_MAX   = 32767;
    localparam int AMP_MIN   = -32768;
    localparam int HOLD_LEN  = 600;
    localparam int LIMIT     = 1000000;
    localparam int MAX_LINES = 40;

    // The op code that the block has to ignore.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [NQ_MAX-1:0]        index;
        logic signed [AMP_W-1:0]  re;
        logic signed [AMP_W-1:0]  im;
    } t_amp_op;

    typedef struct {
        logic signed [AMP_W-1:0]  re;
        logic signed [AMP_W-1:0]  im;
        logic                     kind;
        logic                     status;
    } t_amp_result;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data  = '0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    logic [OP_W-1:0]          i_op        = '0;
    logic [NQ_MAX-1:0]        i_index     = '0;
    logic signed [AMP_W-1:0]  i_in_real   = '0;
    logic signed [AMP_W-1:0]  i_in_imag   = '0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    logic signed [AMP_W-1:0]  o_out_real;
    logic signed [AMP_W-1:0]  o_out_imag;
    logic                     o_kind;
    logic                     o_status;

    hadamard_gate_state_vector #(
        .MAX_QUBITS (NQ_MAX),
        .AMP_WIDTH  (AMP_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_in_real   (i_in_real),
        .i_in_imag   (i_in_imag),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_real  (o_out_real),
        .o_out_imag  (o_out_imag),
        .o_kind      (o_kind),
        .o_status    (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_amp_op                  op_queue[$];
    t_amp_result              answer_q[$];
    logic signed [AMP_W-1:0]  amp_re[DEPTH];
    logic signed [AMP_W-1:0]  amp_im[DEPTH];
    bit                       gen_written[DEPTH];
    logic [CFG_W-1:0]         cfg_qubits = QUBIT_COUNT_RST;
    logic [CFG_W-1:0]         cfg_target = TARGET_QUBIT_RST;
    int                       errors     = 0;
    int                       cycle_cnt  = 0;
    int                       tx_idle_pct = 0;
    int                       rx_idle_pct = 0;
    logic                     hold_arm   = 1'b0;
    int                       hold_count = 0;
    logic                     rx_hold;

    assign rx_hold = hold_arm && (hold_count < HOLD_LEN);

    task automatic note_mismatch(input string what, input int got, input int want);
        if (errors < MAX_LINES)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Multiply by 1/sqrt2 in Q0.16, round half up, saturate to the amplitude range.
    function automatic logic signed [AMP_W-1:0] scale_inv_sqrt2(input int s);
        longint p;
        p = longint'(s) * longint'(INV_SQRT2_Q16) + longint'(32768);
        p = p >>> 16;
        if (p > longint'(AMP_MAX))
            p = longint'(AMP_MAX);
        else if (p < longint'(AMP_MIN))
            p = longint'(AMP_MIN);
        return p[AMP_W-1:0];
    endfunction

    function automatic logic apply_hadamard();
        int n;
        int k;
        int mask;
        int j;
        logic signed [AMP_W-1:0] ar, ai, br, bi;
        n = (cfg_qubits > NQ_MAX) ? NQ_MAX : int'(cfg_qubits);
        k = int'(cfg_target);
        if (k < 1 || k > n)
            return STATUS_BAD_TARGET;
        mask = 1 << (n - k);
        for (int i = 0; i < (1 << n); i++) begin
            if ((i & mask) == 0) begin
                j  = i ^ mask;
                ar = amp_re[i];
                ai = amp_im[i];
                br = amp_re[j];
                bi = amp_im[j];
                amp_re[i] = scale_inv_sqrt2(int'(ar) + int'(br));
                amp_im[i] = scale_inv_sqrt2(int'(ai) + int'(bi));
                amp_re[j] = scale_inv_sqrt2(int'(ar) - int'(br));
                amp_im[j] = scale_inv_sqrt2(int'(ai) - int'(bi));
            end
        end
        return STATUS_OK;
    endfunction

    task automatic predict_op(input t_amp_op item);
        t_amp_result res;
        res.re     = '0;
        res.im     = '0;
        res.status = STATUS_OK;
        case (item.op)
            OP_WRITE: begin
                amp_re[item.index] = item.re;
                amp_im[item.index] = item.im;
            end
            OP_GATE: begin
                res.kind   = KIND_GATE;
                res.status = apply_hadamard();
                answer_q.push_back(res);
            end
            OP_READ: begin
                res.kind = KIND_READ;
                res.re   = amp_re[item.index];
                res.im   = amp_im[item.index];
                answer_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : item_driver
        t_amp_op cur;
        t_amp_op nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                cur.op    = i_op;
                cur.index = i_index;
                cur.re    = i_in_real;
                cur.im    = i_in_imag;
                predict_op(cur);
            end
            if (!i_valid || o_ready) begin
                if (op_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = op_queue.pop_front();
                    i_valid   <= 1'b1;
                    i_op      <= nxt.op;
                    i_index   <= nxt.index;
                    i_in_real <= nxt.re;
                    i_in_imag <= nxt.im;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_amp_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (answer_q.size() == 0) begin
                    note_mismatch("result with nothing pending, kind", int'(o_kind), -1);
                end else begin
                    want = answer_q.pop_front();
                    if (o_out_real !== want.re)
                        note_mismatch("out_real", int'(o_out_real), int'(want.re));
                    if (o_out_imag !== want.im)
                        note_mismatch("out_imag", int'(o_out_imag), int'(want.im));
                    if (o_kind !== want.kind)
                        note_mismatch("kind", int'(o_kind), int'(want.kind));
                    if (o_status !== want.status)
                        note_mismatch("status", int'(o_status), int'(want.status));
                end
            end
            i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall, counted here once armed.
    always @(posedge i_clk) begin : receiver_hold
        if (rx_hold)
            hold_count <= hold_count + 1;
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int rand_amp();
        case ($urandom_range(7))
            0:       return AMP_MAX;
            1:       return AMP_MIN;
            default: return int'($urandom_range(65535)) + AMP_MIN;
        endcase
    endfunction

    task automatic push_op(input logic [OP_W-1:0] op, input int idx, input int re,
                           input int im);
        t_amp_op item;
        item.op    = op;
        item.index = NQ_MAX'(idx);
        item.re    = AMP_W'(re);
        item.im    = AMP_W'(im);
        if (op == OP_WRITE)
            gen_written[item.index] = 1'b1;
        op_queue.push_back(item);
    endtask

    // Every entry a gate touches must hold a written value first.
    task automatic fill_span(input int span);
        for (int i = 0; i < span; i++)
            if (!gen_written[i])
                push_op(OP_WRITE, i, rand_amp(), rand_amp());
    endtask

    function automatic int pick_written(input int span);
        int idx;
        for (int t = 0; t < 64; t++) begin
            idx = ($urandom_range(3) == 0) ? int'($urandom_range(DEPTH - 1))
                                           : int'($urandom_range(span - 1));
            if (gen_written[idx])
                return idx;
        end
        return 0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_cfg(input logic [CFG_W-1:0] nq, input logic [CFG_W-1:0] tq);
        write_reg(REG_QUBIT_COUNT, nq);
        write_reg(REG_TARGET_QUBIT, tq);
        cfg_qubits = nq;
        cfg_target = tq;
    endtask

    task automatic set_idle(input int tx, input int rx);
        @(posedge i_clk);
        tx_idle_pct <= tx;
        rx_idle_pct <= rx;
    endtask

    // Wait until every item is taken and every result has come back, then let
    // a trailing write settle.
    task automatic drain();
        @(negedge i_clk);
        while (op_queue.size() != 0 || i_valid || answer_q.size() != 0)
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] nq, input logic [CFG_W-1:0] tq,
                             input int count, input int gate_pct, input bit prefill,
                             input bit hold_off);
        int eff;
        int span;
        int gate_cap;
        int gates;
        int done_ops;
        int r;
        bit target_ok;
        drain();
        set_cfg(nq, tq);
        eff       = (nq > NQ_MAX) ? NQ_MAX : int'(nq);
        span      = 1 << eff;
        target_ok = (tq >= 1) && (int'(tq) <= eff);
        gate_cap  = (eff >= 8) ? 3 : count;
        gates     = 0;
        done_ops  = 0;
        if (prefill)
            fill_span(span);
        if (hold_off) begin
            @(posedge i_clk);
            hold_arm <= 1'b1;
        end
        while (done_ops < count) begin
            r = int'($urandom_range(99));
            if (r < gate_pct && gates < gate_cap) begin
                if (target_ok)
                    fill_span(span);
                push_op(OP_GATE, int'($urandom), rand_amp(), rand_amp());
                gates++;
                done_ops++;
            end else if (r < gate_pct + 40) begin
                push_op(OP_READ, pick_written(span), rand_amp(), rand_amp());
                done_ops++;
            end else if (r < 96) begin
                push_op(OP_WRITE,
                        ($urandom_range(3) == 0) ? int'($urandom_range(DEPTH - 1))
                                                 : int'($urandom_range(span - 1)),
                        rand_amp(), rand_amp());
                done_ops++;
            end else begin
                push_op(OP_SPARE, int'($urandom), rand_amp(), rand_amp());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme values and indices, the ignored op code,
        // saturating gates on one qubit and every out-of-range target case.
        set_idle(22, 88);
        push_op(OP_WRITE, 0, AMP_MAX, AMP_MIN);
        push_op(OP_WRITE, DEPTH - 1, AMP_MIN, AMP_MAX);
        push_op(OP_WRITE, 1, 0, -1);
        push_op(OP_READ, 0, 0, 0);
        push_op(OP_READ, DEPTH - 1, 0, 0);
        push_op(OP_READ, 1, 0, 0);
        push_op(OP_SPARE, 0, 'h5555, 'h2aaa);
        push_op(OP_READ, 0, 0, 0);
        drain();
        set_cfg(4'd1, 4'd1);
        push_op(OP_WRITE, 0, AMP_MAX, AMP_MAX);
        push_op(OP_WRITE, 1, AMP_MAX, AMP_MIN);
        push_op(OP_GATE, 0, 0, 0);
        push_op(OP_READ, 0, 0, 0);
        push_op(OP_READ, 1, 0, 0);
        push_op(OP_WRITE, 0, AMP_MIN, AMP_MIN);
        push_op(OP_WRITE, 1, AMP_MIN, AMP_MAX);
        push_op(OP_GATE, DEPTH - 1, -1, -1);
        push_op(OP_READ, 0, 0, 0);
        push_op(OP_READ, 1, 0, 0);
        drain();
        set_cfg(4'd1, 4'd0);
        push_op(OP_GATE, 0, 0, 0);
        drain();
        set_cfg(4'd1, 4'd2);
        push_op(OP_GATE, 0, 0, 0);
        drain();
        set_cfg(4'd0, 4'd1);
        push_op(OP_GATE, 0, 0, 0);
        push_op(OP_READ, 1, 0, 0);

        // Random: sender idles lightly, receiver heavily.
        run_phase(4'd10, 4'd10, 90, 3, 1'b1, 1'b0);
        run_phase(4'd3, 4'd2, 80, 25, 1'b0, 1'b0);
        run_phase(4'd4, 4'd0, 40, 25, 1'b0, 1'b0);

        set_idle(88, 22);
        run_phase(4'd2, 4'd1, 80, 25, 1'b0, 1'b0);
        run_phase(4'd1, 4'd1, 50, 30, 1'b0, 1'b0);
        run_phase(4'd15, 4'd1, 30, 5, 1'b0, 1'b0);

        set_idle(0, 0);
        run_phase(4'd5, 4'd5, 80, 20, 1'b0, 1'b1);
        run_phase(4'd0, 4'd15, 25, 25, 1'b0, 1'b0);
        run_phase(4'd6, 4'd7, 25, 25, 1'b0, 1'b0);
        run_phase(4'd4, 4'd3, 70, 25, 1'b0, 1'b0);
        run_phase(4'd9, 4'd4, 30, 5, 1'b0, 1'b0);

        drain();
        repeat (20) @(posedge i_clk);
        if (answer_q.size() != 0)
            note_mismatch("results never delivered", 0, answer_q.size());
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
